@@ rtl/rar_pkg.sv @@
// ----------------------------------------------------------------------------
// rar_pkg: shared types and microcode for the fraction arithmetic block
// Holds the command and result words, the sequencer control word, the
// microprogram ROM and the request word of the iterative arithmetic unit.
// ----------------------------------------------------------------------------
package rar_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DATA_W);
	localparam int PC_W   = 5;

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [1:0] {
		F_ADD     = 2'd0,
		F_ADD_INT = 2'd1,
		F_MUL     = 2'd2,
		F_REDUCE  = 2'd3
	} func_t;

	typedef struct packed {
		func_t                    func;
		logic                     reduce_result;
		logic signed [DATA_W-1:0] num_a;
		logic signed [DATA_W-1:0] den_a;
		logic signed [DATA_W-1:0] num_b;
		logic signed [DATA_W-1:0] den_b;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] num_out;
		logic signed [DATA_W-1:0] den_out;
		logic                     zero_den_error;
	} res_t;

	// iterative unit operations
	typedef enum logic [1:0] {
		U_MUL = 2'd0,
		U_DIV = 2'd1,
		U_GCD = 2'd2
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_req_t;

	// micro-operations
	typedef enum logic [2:0] {
		OP_NOP  = 3'd0,
		OP_MOV  = 3'd1,
		OP_ADD  = 3'd2,
		OP_ERRZ = 3'd3,
		OP_MUL  = 3'd4,
		OP_GCD  = 3'd5,
		OP_DIV  = 3'd6,
		OP_DONE = 3'd7
	} uop_t;

	// register file selects
	typedef enum logic [2:0] {
		R_NA  = 3'd0,
		R_DA  = 3'd1,
		R_NB  = 3'd2,
		R_DB  = 3'd3,
		R_RN  = 3'd4,
		R_RD  = 3'd5,
		R_T   = 3'd6,
		R_ONE = 3'd7
	} rsel_t;

	// jump conditions
	typedef enum logic [2:0] {
		J_NONE     = 3'd0,
		J_ALWAYS   = 3'd1,
		J_DISPATCH = 3'd2,
		J_NOT_RED  = 3'd3,
		J_NE       = 3'd4,
		J_LE1      = 3'd5
	} jcond_t;

	typedef struct packed {
		uop_t   op;
		rsel_t  src_a;
		rsel_t  src_b;
		rsel_t  dst;
		jcond_t jc;
		pc_t    target;
	} ucode_t;

	// program labels
	localparam pc_t UA_DISPATCH  = 5'd0;
	localparam pc_t UA_F_ADD     = 5'd1;
	localparam pc_t UA_F_ADD_INT = 5'd6;
	localparam pc_t UA_F_MUL     = 5'd9;
	localparam pc_t UA_F_REDUCE  = 5'd12;
	localparam pc_t UA_CHECK     = 5'd14;
	localparam pc_t UA_EQUAL     = 5'd16;
	localparam pc_t UA_GCD       = 5'd18;
	localparam pc_t UA_END       = 5'd22;

	function automatic ucode_t mk(uop_t op, rsel_t sa, rsel_t sb, rsel_t dst,
			jcond_t jc, pc_t tgt);
		ucode_t w;
		w.op     = op;
		w.src_a  = sa;
		w.src_b  = sb;
		w.dst    = dst;
		w.jc     = jc;
		w.target = tgt;
		return w;
	endfunction

	// microprogram; unlisted addresses finish the item
	function automatic ucode_t ucode_rom(pc_t pc);
		ucode_t w;
		case (pc)
			UA_DISPATCH:       w = mk(OP_ERRZ, R_DA, R_DA, R_T, J_DISPATCH, UA_DISPATCH);
			// add fractions
			UA_F_ADD:          w = mk(OP_ERRZ, R_DB, R_DB, R_T, J_NONE, UA_DISPATCH);
			UA_F_ADD + 5'd1:   w = mk(OP_MUL, R_NA, R_DB, R_RN, J_NONE, UA_DISPATCH);
			UA_F_ADD + 5'd2:   w = mk(OP_MUL, R_NB, R_DA, R_T, J_NONE, UA_DISPATCH);
			UA_F_ADD + 5'd3:   w = mk(OP_ADD, R_RN, R_T, R_RN, J_NONE, UA_DISPATCH);
			UA_F_ADD + 5'd4:   w = mk(OP_MUL, R_DB, R_DA, R_RD, J_ALWAYS, UA_CHECK);
			// add integer
			UA_F_ADD_INT:      w = mk(OP_MUL, R_NB, R_DA, R_T, J_NONE, UA_DISPATCH);
			UA_F_ADD_INT + 5'd1: w = mk(OP_ADD, R_NA, R_T, R_RN, J_NONE, UA_DISPATCH);
			UA_F_ADD_INT + 5'd2: w = mk(OP_MOV, R_DA, R_DA, R_RD, J_ALWAYS, UA_CHECK);
			// multiply
			UA_F_MUL:          w = mk(OP_ERRZ, R_DB, R_DB, R_T, J_NONE, UA_DISPATCH);
			UA_F_MUL + 5'd1:   w = mk(OP_MUL, R_NA, R_NB, R_RN, J_NONE, UA_DISPATCH);
			UA_F_MUL + 5'd2:   w = mk(OP_MUL, R_DA, R_DB, R_RD, J_ALWAYS, UA_CHECK);
			// reduce first fraction
			UA_F_REDUCE:       w = mk(OP_MOV, R_NA, R_NA, R_RN, J_NONE, UA_DISPATCH);
			UA_F_REDUCE + 5'd1: w = mk(OP_MOV, R_DA, R_DA, R_RD, J_NONE, UA_DISPATCH);
			// common tail
			UA_CHECK:          w = mk(OP_ERRZ, R_RD, R_RD, R_T, J_NOT_RED, UA_END);
			UA_CHECK + 5'd1:   w = mk(OP_NOP, R_RN, R_RD, R_T, J_NE, UA_GCD);
			UA_EQUAL:          w = mk(OP_MOV, R_ONE, R_ONE, R_RN, J_NONE, UA_DISPATCH);
			UA_EQUAL + 5'd1:   w = mk(OP_MOV, R_ONE, R_ONE, R_RD, J_ALWAYS, UA_END);
			UA_GCD:            w = mk(OP_GCD, R_RN, R_RD, R_T, J_NONE, UA_DISPATCH);
			UA_GCD + 5'd1:     w = mk(OP_NOP, R_T, R_T, R_T, J_LE1, UA_END);
			UA_GCD + 5'd2:     w = mk(OP_DIV, R_RN, R_T, R_RN, J_NONE, UA_DISPATCH);
			UA_GCD + 5'd3:     w = mk(OP_DIV, R_RD, R_T, R_RD, J_NONE, UA_DISPATCH);
			default:           w = mk(OP_DONE, R_RN, R_RD, R_T, J_NONE, UA_DISPATCH);
		endcase
		return w;
	endfunction

	function automatic pc_t entry(func_t f);
		pc_t p;
		case (f)
			F_ADD:     p = UA_F_ADD;
			F_ADD_INT: p = UA_F_ADD_INT;
			F_MUL:     p = UA_F_MUL;
			F_REDUCE:  p = UA_F_REDUCE;
			default:   p = UA_END;
		endcase
		return p;
	endfunction

endpackage

@@ rtl/rational_arith_reduce.sv @@
// ----------------------------------------------------------------------------
// rational_arith_reduce: fraction arithmetic with gcd reduction
// Adds, multiplies or reduces fractions under control of a microprogram.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the word is taken at a rising
//   edge with start high and busy low. busy stays high until the result has
//   been presented, so one command is in flight at a time.
//   Result channel: done is high for exactly one cycle with the result word
//   on result; the receiver must take it then, there is no back-pressure.
//   The sequencer steps through the microprogram and waits on the iterative
//   unit for each multiply, divide and gcd; the unit takes one step per
//   cycle, and a multiply ends early when the multiplier has leading zeros.
//   Add integer without reduction is the shortest kind of item and add
//   fractions with reduction the longest; the shared multiply/divide/gcd
//   unit sets the time an item takes. The next command can be taken in
//   the cycle done is high.
//   Reset: arst_n clears the sequencer to idle and drops done; no result is
//   lost or invented by a reset between commands.
//   Zero denominators only raise zero_den_error; the arithmetic still runs.
// ----------------------------------------------------------------------------
module rational_arith_reduce (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rar_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output rar_pkg::res_t result
);

	localparam int W = rar_pkg::DATA_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

	state_t             state_q;
	rar_pkg::pc_t       pc_q, pc_next;
	rar_pkg::ucode_t    uw;
	rar_pkg::func_t     func_q;
	rar_pkg::unit_req_t ureq;
	rar_pkg::res_t      result_q;
	logic               red_q, err_q, done_q;
	logic [W-1:0]       na_q, da_q, nb_q, db_q, rn_q, rd_q, t_q;
	logic [W-1:0]       opa, opb, wr_data, u_res;
	logic               wr_en, u_done, accept;

	function automatic logic [W-1:0] rd_sel(rar_pkg::rsel_t s, logic [W-1:0] na,
			logic [W-1:0] da, logic [W-1:0] nb, logic [W-1:0] db,
			logic [W-1:0] rn, logic [W-1:0] rd, logic [W-1:0] t);
		logic [W-1:0] v;
		case (s)
			rar_pkg::R_NA:  v = na;
			rar_pkg::R_DA:  v = da;
			rar_pkg::R_NB:  v = nb;
			rar_pkg::R_DB:  v = db;
			rar_pkg::R_RN:  v = rn;
			rar_pkg::R_RD:  v = rd;
			rar_pkg::R_T:   v = t;
			rar_pkg::R_ONE: v = W'(1);
			default:        v = '0;
		endcase
		return v;
	endfunction

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// fetch the control word of the current step and its operands
	assign uw  = rar_pkg::ucode_rom(pc_q);
	assign opa = rd_sel(uw.src_a, na_q, da_q, nb_q, db_q, rn_q, rd_q, t_q);
	assign opb = rd_sel(uw.src_b, na_q, da_q, nb_q, db_q, rn_q, rd_q, t_q);

	// next step: fall through or take the jump
	always_comb begin
		pc_next = pc_q + rar_pkg::PC_W'(1);
		case (uw.jc)
			rar_pkg::J_ALWAYS:   pc_next = uw.target;
			rar_pkg::J_DISPATCH: pc_next = rar_pkg::entry(func_q);
			rar_pkg::J_NOT_RED:  if (!red_q) pc_next = uw.target;
			rar_pkg::J_NE:       if (opa != opb) pc_next = uw.target;
			rar_pkg::J_LE1:      if (opa <= W'(1)) pc_next = uw.target;
			default: ;
		endcase
	end

	// issue multi-cycle operations to the iterative unit
	always_comb begin
		ureq.start = 1'b0;
		ureq.op    = rar_pkg::U_MUL;
		if (state_q == ST_RUN) begin
			case (uw.op)
				rar_pkg::OP_MUL: begin
					ureq.start = 1'b1;
					ureq.op    = rar_pkg::U_MUL;
				end
				rar_pkg::OP_GCD: begin
					ureq.start = 1'b1;
					ureq.op    = rar_pkg::U_GCD;
				end
				rar_pkg::OP_DIV: begin
					ureq.start = 1'b1;
					ureq.op    = rar_pkg::U_DIV;
				end
				default: ;
			endcase
		end
	end

	rar_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.a      (opa),
		.b      (opb),
		.done   (u_done),
		.res    (u_res)
	);

	// register file write-back
	always_comb begin
		wr_en   = 1'b0;
		wr_data = opa;
		case (state_q)
			ST_RUN: begin
				case (uw.op)
					rar_pkg::OP_MOV: wr_en = 1'b1;
					rar_pkg::OP_ADD: begin
						wr_en   = 1'b1;
						wr_data = opa + opb;
					end
					default: ;
				endcase
			end
			ST_WAIT: begin
				wr_en   = u_done;
				wr_data = u_res;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= rar_pkg::UA_DISPATCH;
			done_q  <= 1'b0;
			err_q   <= 1'b0;
			red_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						pc_q    <= rar_pkg::UA_DISPATCH;
						err_q   <= 1'b0;
						// reduce is forced for the reduce operation
						red_q   <= cmd.reduce_result || (cmd.func == rar_pkg::F_REDUCE);
					end
				end
				ST_RUN: begin
					case (uw.op)
						rar_pkg::OP_MUL, rar_pkg::OP_GCD, rar_pkg::OP_DIV:
							state_q <= ST_WAIT;
						rar_pkg::OP_DONE: begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
						rar_pkg::OP_ERRZ: begin
							err_q <= err_q || (opa == '0);
							pc_q  <= pc_next;
						end
						default: pc_q <= pc_next;
					endcase
				end
				ST_WAIT: begin
					// hold the step until the unit hands back its word
					if (u_done) begin
						pc_q    <= pc_next;
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operand and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= cmd.func;
			na_q   <= cmd.num_a;
			da_q   <= cmd.den_a;
			nb_q   <= cmd.num_b;
			db_q   <= cmd.den_b;
		end else if (wr_en) begin
			case (uw.dst)
				rar_pkg::R_NA: na_q <= wr_data;
				rar_pkg::R_DA: da_q <= wr_data;
				rar_pkg::R_NB: nb_q <= wr_data;
				rar_pkg::R_DB: db_q <= wr_data;
				rar_pkg::R_RN: rn_q <= wr_data;
				rar_pkg::R_RD: rd_q <= wr_data;
				rar_pkg::R_T:  t_q  <= wr_data;
				default: ;
			endcase
		end
		if (state_q == ST_RUN && uw.op == rar_pkg::OP_DONE) begin
			result_q.num_out        <= rn_q;
			result_q.den_out        <= rd_q;
			result_q.zero_den_error <= err_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted word did not make the block busy");

	a_done_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_RUN))
		else $error("result strobe not issued by a finishing step");

	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result words in a row");

	a_zero_den_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.den_out == '0) |-> result.zero_den_error)
		else $error("zero denominator delivered without error flag");

	a_wait_unit_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |->
		(uw.op == rar_pkg::OP_MUL || uw.op == rar_pkg::OP_GCD ||
		 uw.op == rar_pkg::OP_DIV))
		else $error("waiting on the unit for a single-cycle step");
`endif

endmodule

@@ rtl/rar_iter_unit.sv @@
// ----------------------------------------------------------------------------
// rar_iter_unit: iterative multiply, divide and gcd unit
// Shift-add low-half multiply, restoring signed-by-unsigned division and
// binary gcd of magnitudes, one step per cycle. Pulses done with the result.
// ----------------------------------------------------------------------------
module rar_iter_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rar_pkg::unit_req_t         req,
	input  logic [rar_pkg::DATA_W-1:0] a,
	input  logic [rar_pkg::DATA_W-1:0] b,
	output logic                       done,
	output logic [rar_pkg::DATA_W-1:0] res
);

	localparam int W  = rar_pkg::DATA_W;
	localparam int KW = rar_pkg::CNT_W;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_MUL    = 6'b000010,
		PH_DIV    = 6'b000100,
		PH_GTWO   = 6'b001000,
		PH_GRUN   = 6'b010000,
		PH_GSHIFT = 6'b100000
	} phase_t;

	phase_t          phase_q, phase_d;
	logic            done_q, done_d;
	logic [W-1:0]    x_q, x_d, y_q, y_d, res_q, res_d;
	logic [W-1:0]    acc_q, acc_d;
	logic [KW-1:0]   k_q, k_d;
	logic            neg_q, neg_d;
	logic [W-1:0]    a_mag, b_mag;
	logic [W:0]      trial;
	logic            trial_ge;

	assign a_mag    = a[W-1] ? ('0 - a) : a;
	assign b_mag    = b[W-1] ? ('0 - b) : b;
	assign trial    = {acc_q, x_q[W-1]};
	assign trial_ge = trial >= {1'b0, y_q};

	always_comb begin
		phase_d = phase_q;
		done_d  = 1'b0;
		x_d     = x_q;
		y_d     = y_q;
		acc_d   = acc_q;
		k_d     = k_q;
		neg_d   = neg_q;
		res_d   = res_q;
		case (phase_q)
			PH_IDLE: begin
				if (req.start) begin
					case (req.op)
						rar_pkg::U_MUL: begin
							x_d     = a;
							y_d     = b;
							acc_d   = '0;
							phase_d = PH_MUL;
						end
						rar_pkg::U_DIV: begin
							x_d     = a_mag;
							y_d     = b;
							acc_d   = '0;
							neg_d   = a[W-1];
							k_d     = KW'(W - 1);
							phase_d = PH_DIV;
						end
						rar_pkg::U_GCD: begin
							x_d     = a_mag;
							y_d     = b_mag;
							k_d     = '0;
							phase_d = PH_GTWO;
						end
						default: ;
					endcase
				end
			end
			PH_MUL: begin
				if (y_q == '0) begin
					res_d   = acc_q;
					done_d  = 1'b1;
					phase_d = PH_IDLE;
				end else begin
					if (y_q[0])
						acc_d = acc_q + x_q;
					x_d = x_q << 1;
					y_d = y_q >> 1;
				end
			end
			PH_DIV: begin
				// the partial remainder stays below the divisor
				if (trial_ge) begin
					acc_d = W'(trial - {1'b0, y_q});
					x_d   = {x_q[W-2:0], 1'b1};
				end else begin
					acc_d = trial[W-1:0];
					x_d   = {x_q[W-2:0], 1'b0};
				end
				if (k_q == '0) begin
					res_d   = neg_q ? ('0 - x_d) : x_d;
					done_d  = 1'b1;
					phase_d = PH_IDLE;
				end else begin
					k_d = k_q - KW'(1);
				end
			end
			PH_GTWO: begin
				// strip common factors of two, counted in k
				if (x_q == '0 || y_q == '0) begin
					x_d     = x_q | y_q;
					phase_d = PH_GSHIFT;
				end else if (!x_q[0] && !y_q[0]) begin
					x_d = x_q >> 1;
					y_d = y_q >> 1;
					k_d = k_q + KW'(1);
				end else begin
					phase_d = PH_GRUN;
				end
			end
			PH_GRUN: begin
				if (x_q == '0) begin
					x_d     = y_q;
					phase_d = PH_GSHIFT;
				end else if (y_q == '0) begin
					phase_d = PH_GSHIFT;
				end else if (!x_q[0]) begin
					x_d = x_q >> 1;
				end else if (!y_q[0]) begin
					y_d = y_q >> 1;
				end else if (x_q >= y_q) begin
					x_d = (x_q - y_q) >> 1;
				end else begin
					y_d = (y_q - x_q) >> 1;
				end
			end
			PH_GSHIFT: begin
				// restore the common twos
				if (k_q == '0) begin
					res_d   = x_q;
					done_d  = 1'b1;
					phase_d = PH_IDLE;
				end else begin
					x_d = x_q << 1;
					k_d = k_q - KW'(1);
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		x_q   <= x_d;
		y_q   <= y_d;
		acc_q <= acc_d;
		k_q   <= k_d;
		neg_q <= neg_d;
		res_q <= res_d;
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for rational_arith_reduce
// Sends command words over the start/busy channel and checks every result
// word taken on the done strobe against a fraction calculator kept here.
// A directed opening covers the operation codes, zero denominators, equal
// terms and the extreme values. About 1200 random words follow, in three
// phases of sender idling.
// ----------------------------------------------------------------------------
module tb;
	import rar_pkg::*;

	// a queued command word, with a flag to hold it back until the block
	// has gone quiet (every expected result received)
	typedef struct {
		cmd_t word;
		bit   settle;
	} queued_cmd_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic done;
	res_t result;

	queued_cmd_t cmd_backlog[$];   // words still to be sent
	res_t        due_results[$];   // predicted results, oldest first

	bit word_taken = 1'b0;         // command word taken at the last rising edge
	int gap_left   = 0;            // remaining cycles of a sender pause
	int n_taken    = 0;
	int n_checked  = 0;
	int n_flagged  = 0;
	int n_errors   = 0;
	int n_by_func[4];

	rational_arith_reduce u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Fraction calculator. Sums and products wrap to DATA_W bits; reduction
	// works on magnitudes so the most negative value divides exactly, and
	// the sign of each term is put back after the division.
	// ------------------------------------------------------------------------
	function automatic logic [DATA_W-1:0] abs_word(logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? -v : v;
	endfunction

	function automatic logic [DATA_W-1:0] div_keep_sign(logic [DATA_W-1:0] v,
			logic [DATA_W-1:0] g);
		logic [DATA_W-1:0] q;
		q = abs_word(v) / g;
		return v[DATA_W-1] ? -q : q;
	endfunction

	function automatic res_t frac_eval(cmd_t c);
		logic [DATA_W-1:0] na, da, nb, db, rn, rd, x, y, r;
		logic              red, err;
		res_t              o;
		na  = c.num_a;
		da  = c.den_a;
		nb  = c.num_b;
		db  = c.den_b;
		red = c.reduce_result;
		err = (da == '0);
		case (c.func)
			F_ADD: begin
				rn  = na * db + nb * da;
				rd  = db * da;
				err = err | (db == '0);
			end
			F_ADD_INT: begin
				rn = na + nb * da;
				rd = da;
			end
			F_MUL: begin
				rn  = na * nb;
				rd  = da * db;
				err = err | (db == '0);
			end
			default: begin
				// reduce always happens here, whatever the flag says
				rn  = na;
				rd  = da;
				red = 1'b1;
			end
		endcase
		if (rd == '0)
			err = 1'b1;
		if (red) begin
			if (rn == rd) begin
				// equal terms, 0/0 included, collapse to 1/1
				rn = 1;
				rd = 1;
			end else begin
				x = abs_word(rn);
				y = abs_word(rd);
				while (y != '0) begin
					r = x % y;
					x = y;
					y = r;
				end
				// a gcd of 0 or 1 leaves the terms alone
				if (x > 1) begin
					rn = div_keep_sign(rn, x);
					rd = div_keep_sign(rd, x);
				end
			end
		end
		o.num_out        = rn;
		o.den_out        = rd;
		o.zero_den_error = err;
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_cmd(func_t f, logic red, logic [DATA_W-1:0] na,
			logic [DATA_W-1:0] da, logic [DATA_W-1:0] nb,
			logic [DATA_W-1:0] db, bit settle);
		queued_cmd_t q;
		q.word.func          = f;
		q.word.reduce_result = red;
		q.word.num_a         = na;
		q.word.den_a         = da;
		q.word.num_b         = nb;
		q.word.den_b         = db;
		q.settle             = settle;
		cmd_backlog.push_back(q);
	endtask

	// Mix full-range words, extremes, small values and multiples of a shared
	// factor; the last kind gives the gcd something real to divide out.
	function automatic logic [DATA_W-1:0] pick_operand(logic [DATA_W-1:0] factor);
		logic [DATA_W-1:0] v;
		case ($urandom_range(9))
			0, 1, 2: v = $urandom;
			3: begin
				case ($urandom_range(4))
					0:       v = {1'b1, {(DATA_W-1){1'b0}}};
					1:       v = {1'b0, {(DATA_W-1){1'b1}}};
					2:       v = '0;
					3:       v = 1;
					default: v = '1;
				endcase
			end
			4, 5:    v = $urandom_range(200) - 100;
			default: v = factor * ($urandom_range(40) - 20);
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// Result checker and command-acceptance tracker, both at the rising edge.
	// Check any result first, then log a word taken at the same edge, since
	// the block may take the next word in the cycle done is high.
	// ------------------------------------------------------------------------
	task automatic note_mismatch(string what, res_t want, res_t got);
		n_errors++;
		if (n_errors <= 10)
			$display("tb: %0t %s: expected %0d/%0d err=%0b, got %0d/%0d err=%0b",
				$realtime, what, want.num_out, want.den_out, want.zero_den_error,
				got.num_out, got.den_out, got.zero_den_error);
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (done) begin
				if (due_results.size() == 0) begin
					note_mismatch("unexpected result", '0, result);
				end else begin
					want = due_results.pop_front();
					n_checked++;
					if (result.zero_den_error)
						n_flagged++;
					if (result.num_out !== want.num_out
							|| result.den_out !== want.den_out
							|| result.zero_den_error !== want.zero_den_error)
						note_mismatch("result mismatch", want, result);
				end
			end
			word_taken = start && !busy;
			if (word_taken) begin
				due_results.push_back(frac_eval(cmd));
				n_by_func[cmd.func]++;
				n_taken++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Command driver, at the falling edge. Hold start and the word until the
	// block takes it; then drop the word from the backlog and decide afresh
	// whether to pause or present the next one. Pause lengths come from one of
	// two ranges, so that a new word turns up at every stage of the block's
	// work, including the cycle its result comes out.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		int  idle_pct;
		bit  raise;
		if (arst_n) begin
			if (start && word_taken)
				void'(cmd_backlog.pop_front());
			if (!(start && !word_taken)) begin
				// idling phases: sender pauses often, then more, then never
				idle_pct = (n_taken < 400) ? 36 : (n_taken < 800) ? 54 : 0;
				raise = 1'b0;
				if (gap_left > 0)
					gap_left--;
				else if (cmd_backlog.size() == 0)
					raise = 1'b0;
				else if (cmd_backlog[0].settle && due_results.size() != 0)
					raise = 1'b0;   // wait for the block to drain first
				else if ($urandom_range(99) < idle_pct)
					gap_left = ($urandom_range(2) == 0) ? $urandom_range(300)
						: $urandom_range(3);
				else
					raise = 1'b1;
				start <= raise;
				if (raise)
					cmd <= cmd_backlog[0].word;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence: fill the backlog, reset, then wait for the traffic to
	// finish and report.
	// ------------------------------------------------------------------------
	initial begin
		logic [DATA_W-1:0] factor, na, da;
		logic [DATA_W-1:0] min_w, max_w;
		min_w  = {1'b1, {(DATA_W-1){1'b0}}};
		max_w  = {1'b0, {(DATA_W-1){1'b1}}};
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;

		// directed opening
		queue_cmd(F_ADD,     1'b0, 1, 2, 1, 3, 1'b0);
		queue_cmd(F_ADD,     1'b1, 1, 6, 1, 3, 1'b0);
		queue_cmd(F_ADD_INT, 1'b1, 3, 4, 2, 0, 1'b0);      // den_b ignored
		queue_cmd(F_MUL,     1'b1, 2, 3, 3, 4, 1'b0);
		queue_cmd(F_MUL,     1'b0, -6, 4, 2, -8, 1'b0);
		queue_cmd(F_REDUCE,  1'b0, 12, -18, 5, 0, 1'b0);   // reduces regardless
		queue_cmd(F_REDUCE,  1'b1, 0, 0, 0, 0, 1'b0);      // 0/0 becomes 1/1
		queue_cmd(F_REDUCE,  1'b1, 0, -5, 0, 0, 1'b0);     // zero numerator
		queue_cmd(F_REDUCE,  1'b0, 7, 7, 0, 0, 1'b0);      // equal terms
		queue_cmd(F_ADD,     1'b1, 3, 0, 1, 2, 1'b0);      // zero den_a
		queue_cmd(F_ADD,     1'b1, 3, 5, 1, 0, 1'b0);      // zero den_b
		queue_cmd(F_MUL,     1'b1, 4, 6, 9, 0, 1'b0);
		queue_cmd(F_MUL,     1'b1, 1, 65536, 1, 65536, 1'b0); // denominator wraps to 0
		queue_cmd(F_REDUCE,  1'b1, min_w, min_w, 0, 0, 1'b0);
		queue_cmd(F_REDUCE,  1'b1, min_w, 2, 0, 0, 1'b0);
		queue_cmd(F_REDUCE,  1'b1, max_w, min_w, 0, 0, 1'b0);  // gcd of one
		queue_cmd(F_ADD_INT, 1'b1, '1, '1, '1, '1, 1'b0);
		queue_cmd(F_MUL,     1'b1, max_w, min_w, max_w, min_w, 1'b0);
		queue_cmd(F_ADD,     1'b0, min_w, 1, min_w, 1, 1'b0);
		queue_cmd(F_REDUCE,  1'b1, 5, 7, 0, 0, 1'b0);
		queue_cmd(F_ADD_INT, 1'b0, 9, max_w, min_w, 3, 1'b0);
		queue_cmd(F_MUL,     1'b1, 0, 3, 5, 7, 1'b0);
		queue_cmd(F_ADD,     1'b1, -3, 4, 3, 4, 1'b0);

		// random body; two words hold off until the block is quiet
		for (int i = 0; i < 1200; i++) begin
			factor = ($urandom_range(3) == 0) ? (1 << $urandom_range(20))
				: $urandom_range(1, 5000);
			na = pick_operand(factor);
			da = pick_operand(factor);
			if ($urandom_range(19) == 0)
				da = na;
			queue_cmd(func_t'($urandom_range(3)), 1'($urandom_range(1)), na, da,
				pick_operand(factor), pick_operand(factor), i == 0 || i == 700);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_backlog.size() != 0 || start)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		// hold a while longer to catch any stray result
		repeat (400) @(posedge clk);

		$display("tb: %0d words sent (add %0d, add integer %0d, multiply %0d, reduce %0d)",
			n_taken, n_by_func[F_ADD], n_by_func[F_ADD_INT], n_by_func[F_MUL],
			n_by_func[F_REDUCE]);
		$display("tb: %0d results checked, %0d with zero denominator flagged, %0d mismatches",
			n_checked, n_flagged, n_errors);
		if (n_errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#(64'd30_000_000);
		$display("tb: timeout");
		$display("tb: done, errors");
		$finish;
	end

endmodule
